/* src/i2cm_pkg.sv */
// shared types and constants of the i2c master register access core
package i2cm_pkg;

  localparam int DELAY_W = 16;
  localparam int LEN_W = 16;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd120;
  localparam int QUEUE_DEPTH_DEF = 4;

  // classified command of one input word
  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_BEGIN_WR = 2'd1,
    CMD_BEGIN_RD = 2'd2,
    CMD_DATA     = 2'd3
  } cmd_t;

  // bus phase state
  typedef enum logic [4:0] {
    ST_IDLE   = 5'd0,
    ST_S1     = 5'd1,
    ST_S2     = 5'd2,
    ST_S3     = 5'd3,
    ST_WB_SET = 5'd4,
    ST_WB_HI  = 5'd5,
    ST_WB_LO  = 5'd6,
    ST_WA_SET = 5'd7,
    ST_WA_HI  = 5'd8,
    ST_WA_LO  = 5'd9,
    ST_RB_SET = 5'd10,
    ST_RB_HI  = 5'd11,
    ST_RB_LO  = 5'd12,
    ST_RA_SET = 5'd13,
    ST_RA_HI  = 5'd14,
    ST_RA_LO  = 5'd15,
    ST_P1     = 5'd16,
    ST_P2     = 5'd17,
    ST_P3     = 5'd18,
    ST_NEED   = 5'd19
  } phase_t;

  // which byte is on the bus
  typedef enum logic [1:0] {
    STG_ADDR_W = 2'd0,
    STG_REG    = 2'd1,
    STG_DATA   = 2'd2,
    STG_ADDR_R = 2'd3
  } stage_t;

  // one queued word
  typedef struct packed {
    cmd_t             cmd;
    logic [6:0]       dev_addr;
    logic [7:0]       reg_addr;
    logic [LEN_W-1:0] length;
    logic [7:0]       wr_data;
    logic             sda_in;
  } item_t;

endpackage

/* src/i2cm_front.sv */
// front end: classifies incoming words and pushes them into the queue
module i2cm_front
  import i2cm_pkg::*;
(
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       func,
  input  logic [6:0]       dev_addr,
  input  logic [7:0]       reg_addr,
  input  logic [LEN_W-1:0] length,
  input  logic [7:0]       wr_data,
  input  logic             sda_in,
  input  logic             q_full,
  output logic             q_push,
  output item_t            q_item
);

  cmd_t cmd;

  always_comb begin
    case (func)
      2'd1: cmd = CMD_BEGIN_WR;
      2'd2: cmd = CMD_BEGIN_RD;
      2'd3: cmd = CMD_DATA;
      default: cmd = CMD_TICK;
    endcase
  end

  assign in_stall = q_full;
  assign q_push = in_valid && !q_full;

  always_comb begin
    q_item = '0;
    q_item.cmd = cmd;
    q_item.sda_in = sda_in;
    // address, length and data only matter for the commands that use them
    if (cmd == CMD_BEGIN_WR || cmd == CMD_BEGIN_RD) begin
      q_item.dev_addr = dev_addr;
      q_item.reg_addr = reg_addr;
      q_item.length = length;
    end
    if (cmd == CMD_DATA) begin
      q_item.wr_data = wr_data;
    end
  end

endmodule

/* src/i2cm_fifo.sv */
// short queue between front end and bus engine
module i2cm_fifo
  import i2cm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  pop_valid,
  output item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        if (wr_ptr == PTR_W'(DEPTH - 1)) wr_ptr <= '0;
        else wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        if (rd_ptr == PTR_W'(DEPTH - 1)) rd_ptr <= '0;
        else rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* src/i2cm_engine.sv */
// back end: i2c bus phase engine, one queued word per tick, with output register
module i2cm_engine
  import i2cm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [DELAY_W-1:0] delay_ticks,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               scl_low,
  output logic               sda_low,
  output logic [7:0]         rd_byte,
  output logic               rd_valid,
  output logic               rd_last,
  output logic               need_byte,
  output logic               busy_res,
  output logic               done_res,
  output logic               status
);

  phase_t             phase_state, phase_state_next;
  stage_t             byte_stage, byte_stage_next;
  logic [3:0]         bit_count, bit_count_next;
  logic [7:0]         shift_byte, shift_byte_next;
  logic [LEN_W-1:0]   bytes_left, bytes_left_next;
  logic [DELAY_W-1:0] phase_timer, phase_timer_next;
  logic [6:0]         slave_addr, slave_addr_next;
  logic [7:0]         register_addr, register_addr_next;
  logic               read_mode, read_mode_next;
  logic               scl_drive, scl_drive_next;
  logic               sda_drive, sda_drive_next;
  logic               error_flag, error_flag_next;

  logic [DELAY_W-1:0] eff_delay;
  logic [3:0]         bc_inc;
  logic [7:0]         shift_l;
  logic [LEN_W-1:0]   bl_dec;
  logic [7:0]         rd_byte_next;
  logic               rd_valid_next;
  logic               rd_last_next;
  logic               done_next;
  logic               out_valid_next;

  assign eff_delay = (delay_ticks == '0) ? DELAY_W'(1) : delay_ticks;
  assign bc_inc = bit_count + 4'd1;
  assign shift_l = {shift_byte[6:0], 1'b0};
  assign bl_dec = bytes_left - LEN_W'(1);

  assign q_pop = q_valid && (!out_valid || !out_stall);

  // next state of the bus engine for the word being popped
  always_comb begin
    phase_state_next = phase_state;
    byte_stage_next = byte_stage;
    bit_count_next = bit_count;
    shift_byte_next = shift_byte;
    bytes_left_next = bytes_left;
    phase_timer_next = phase_timer;
    slave_addr_next = slave_addr;
    register_addr_next = register_addr;
    read_mode_next = read_mode;
    scl_drive_next = scl_drive;
    sda_drive_next = sda_drive;
    error_flag_next = error_flag;
    rd_byte_next = '0;
    rd_valid_next = 1'b0;
    rd_last_next = 1'b0;
    done_next = 1'b0;

    if (phase_state == ST_IDLE) begin
      if (q_item.cmd == CMD_BEGIN_WR || q_item.cmd == CMD_BEGIN_RD) begin
        slave_addr_next = q_item.dev_addr;
        register_addr_next = q_item.reg_addr;
        bytes_left_next = q_item.length;
        read_mode_next = (q_item.cmd == CMD_BEGIN_RD);
        byte_stage_next = STG_ADDR_W;
        error_flag_next = 1'b0;
        bit_count_next = '0;
        shift_byte_next = '0;
        scl_drive_next = 1'b0;
        sda_drive_next = 1'b0;
        phase_state_next = ST_S1;
        phase_timer_next = eff_delay;
      end
    end else if (phase_state == ST_NEED) begin
      if (q_item.cmd == CMD_DATA) begin
        shift_byte_next = q_item.wr_data;
        bytes_left_next = bl_dec;
        bit_count_next = '0;
        sda_drive_next = ~q_item.wr_data[7];
        phase_state_next = ST_WB_SET;
        phase_timer_next = eff_delay;
      end
    end else if (phase_timer > DELAY_W'(1)) begin
      phase_timer_next = phase_timer - DELAY_W'(1);
    end else begin
      // end of a bus phase; most arms enter a new phase with a fresh timer
      phase_timer_next = eff_delay;
      case (phase_state)
        ST_S1: begin
          sda_drive_next = 1'b1;
          phase_state_next = ST_S2;
        end
        ST_S2: begin
          scl_drive_next = 1'b1;
          phase_state_next = ST_S3;
        end
        ST_S3: begin
          shift_byte_next = {slave_addr, (byte_stage == STG_ADDR_R)};
          bit_count_next = '0;
          sda_drive_next = ~slave_addr[6];
          phase_state_next = ST_WB_SET;
        end
        ST_WB_SET: begin
          scl_drive_next = 1'b0;
          phase_state_next = ST_WB_HI;
        end
        ST_WB_HI: begin
          scl_drive_next = 1'b1;
          phase_state_next = ST_WB_LO;
        end
        ST_WB_LO: begin
          shift_byte_next = shift_l;
          bit_count_next = bc_inc;
          if (bc_inc >= 4'd8) begin
            sda_drive_next = 1'b0;
            phase_state_next = ST_WA_SET;
          end else begin
            sda_drive_next = ~shift_l[7];
            phase_state_next = ST_WB_SET;
          end
        end
        ST_WA_SET: begin
          scl_drive_next = 1'b0;
          phase_state_next = ST_WA_HI;
        end
        ST_WA_HI: begin
          error_flag_next = q_item.sda_in;
          scl_drive_next = 1'b1;
          phase_state_next = ST_WA_LO;
        end
        ST_WA_LO: begin
          if (error_flag) begin
            sda_drive_next = 1'b1;
            phase_state_next = ST_P1;
          end else begin
            case (byte_stage)
              STG_ADDR_W: begin
                byte_stage_next = STG_REG;
                shift_byte_next = register_addr;
                bit_count_next = '0;
                sda_drive_next = ~register_addr[7];
                phase_state_next = ST_WB_SET;
              end
              STG_REG: begin
                if (read_mode) begin
                  byte_stage_next = STG_ADDR_R;
                  scl_drive_next = 1'b0;
                  sda_drive_next = 1'b0;
                  phase_state_next = ST_S1;
                end else begin
                  byte_stage_next = STG_DATA;
                  if (bytes_left == '0) begin
                    sda_drive_next = 1'b1;
                    phase_state_next = ST_P1;
                  end else begin
                    phase_state_next = ST_NEED;
                  end
                end
              end
              STG_DATA: begin
                if (bytes_left == '0) begin
                  sda_drive_next = 1'b1;
                  phase_state_next = ST_P1;
                end else begin
                  phase_state_next = ST_NEED;
                end
              end
              default: begin
                if (bytes_left == '0) begin
                  sda_drive_next = 1'b1;
                  phase_state_next = ST_P1;
                end else begin
                  shift_byte_next = '0;
                  bit_count_next = '0;
                  sda_drive_next = 1'b0;
                  phase_state_next = ST_RB_SET;
                end
              end
            endcase
          end
        end
        ST_RB_SET: begin
          scl_drive_next = 1'b0;
          phase_state_next = ST_RB_HI;
        end
        ST_RB_HI: begin
          shift_byte_next = {shift_byte[6:0], q_item.sda_in};
          scl_drive_next = 1'b1;
          phase_state_next = ST_RB_LO;
        end
        ST_RB_LO: begin
          bit_count_next = bc_inc;
          if (bc_inc >= 4'd8) begin
            bytes_left_next = bl_dec;
            rd_byte_next = shift_byte;
            rd_valid_next = 1'b1;
            rd_last_next = (bl_dec == '0);
            sda_drive_next = (bl_dec != '0);
            phase_state_next = ST_RA_SET;
          end else begin
            sda_drive_next = 1'b0;
            phase_state_next = ST_RB_SET;
          end
        end
        ST_RA_SET: begin
          scl_drive_next = 1'b0;
          phase_state_next = ST_RA_HI;
        end
        ST_RA_HI: begin
          scl_drive_next = 1'b1;
          phase_state_next = ST_RA_LO;
        end
        ST_RA_LO: begin
          if (bytes_left == '0) begin
            sda_drive_next = 1'b1;
            phase_state_next = ST_P1;
          end else begin
            sda_drive_next = 1'b0;
            bit_count_next = '0;
            shift_byte_next = '0;
            phase_state_next = ST_RB_SET;
          end
        end
        ST_P1: begin
          scl_drive_next = 1'b0;
          phase_state_next = ST_P2;
        end
        ST_P2: begin
          sda_drive_next = 1'b0;
          phase_state_next = ST_P3;
        end
        ST_P3: begin
          phase_state_next = ST_IDLE;
          phase_timer_next = '0;
          done_next = 1'b1;
        end
        default: begin
          phase_state_next = ST_IDLE;
          phase_timer_next = '0;
          scl_drive_next = 1'b0;
          sda_drive_next = 1'b0;
        end
      endcase
    end
  end

  // output word valid flag
  always_comb begin
    if (q_pop) out_valid_next = 1'b1;
    else if (out_valid && out_stall) out_valid_next = 1'b1;
    else out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_state <= ST_IDLE;
      byte_stage <= STG_ADDR_W;
      bit_count <= '0;
      shift_byte <= '0;
      bytes_left <= '0;
      phase_timer <= '0;
      slave_addr <= '0;
      register_addr <= '0;
      read_mode <= 1'b0;
      scl_drive <= 1'b0;
      sda_drive <= 1'b0;
      error_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (q_pop) begin
        phase_state <= phase_state_next;
        byte_stage <= byte_stage_next;
        bit_count <= bit_count_next;
        shift_byte <= shift_byte_next;
        bytes_left <= bytes_left_next;
        phase_timer <= phase_timer_next;
        slave_addr <= slave_addr_next;
        register_addr <= register_addr_next;
        read_mode <= read_mode_next;
        scl_drive <= scl_drive_next;
        sda_drive <= sda_drive_next;
        error_flag <= error_flag_next;
      end
    end
  end

  // output register, loaded with the word's result when it is popped
  always_ff @(posedge clk) begin
    if (q_pop) begin
      scl_low <= scl_drive_next;
      sda_low <= sda_drive_next;
      rd_byte <= rd_byte_next;
      rd_valid <= rd_valid_next;
      rd_last <= rd_last_next;
      need_byte <= (phase_state_next == ST_NEED);
      busy_res <= (phase_state_next != ST_IDLE);
      done_res <= done_next;
      status <= error_flag_next;
    end
  end

  // a running bus phase always has time left on its timer
  assert property (@(posedge clk) disable iff (rst)
    (phase_state != ST_IDLE && phase_state != ST_NEED) |-> (phase_timer != '0))
    else $error("phase timer empty inside a bus phase");

  // a received byte is only reported mid-transaction
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && rd_valid) |-> busy_res)
    else $error("read byte reported while not busy");

  // last-byte mark comes only with a read byte
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && rd_last) |-> rd_valid)
    else $error("rd_last without rd_valid");

  // completion leaves the engine idle
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (!busy_res && !scl_low && !sda_low))
    else $error("done reported with bus still held");

endmodule

/* src/i2c_master_register_access_core.sv */
// top level of the i2c master register access core
// path: a word accepted into the queue is written there, then the engine steps on it
//   into the output register, which drives the result word on the output ports
// throughput: one word per cycle while out_stall is low; the engine steps once per
//   word and the queue of QUEUE_DEPTH words absorbs output stalls
// reset: synchronous rst empties the queue and output register, returns the engine
//   to idle with both lines released and sets delay_ticks to 120
module i2c_master_register_access_core
  import i2cm_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration: ticks per bus phase
  input  logic               cfg_we,
  input  logic [DELAY_W-1:0] cfg_wdata,
  // input words
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic [6:0]         dev_addr,
  input  logic [7:0]         reg_addr,
  input  logic [LEN_W-1:0]   length,
  input  logic [7:0]         wr_data,
  input  logic               sda_in,
  // result words
  output logic               out_valid,
  input  logic               out_stall,
  output logic               scl_low,
  output logic               sda_low,
  output logic [7:0]         rd_byte,
  output logic               rd_valid,
  output logic               rd_last,
  output logic               need_byte,
  output logic               busy_res,
  output logic               done_res,
  output logic               status
);

  // ticks per bus phase, zero is treated as one inside the engine
  logic [DELAY_W-1:0] delay_ticks;

  // front end to queue
  logic  q_full;
  logic  q_push;
  item_t q_push_item;

  // queue to engine
  logic  q_pop;
  logic  q_valid;
  item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= DELAY_RESET;
    end else if (cfg_we) begin
      delay_ticks <= cfg_wdata;
    end
  end

  // classify the incoming word and push it into the queue
  i2cm_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .dev_addr (dev_addr),
    .reg_addr (reg_addr),
    .length   (length),
    .wr_data  (wr_data),
    .sda_in   (sda_in),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_push_item)
  );

  // decouples input stalls from output stalls
  i2cm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  // bus phase engine, one step per word, result held in the output register
  i2cm_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .delay_ticks (delay_ticks),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .scl_low     (scl_low),
    .sda_low     (sda_low),
    .rd_byte     (rd_byte),
    .rd_valid    (rd_valid),
    .rd_last     (rd_last),
    .need_byte   (need_byte),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .status      (status)
  );

endmodule

/* bench/i2c_master_register_access_checker.sv */
// checker for the i2c master register access core: bus predictor and result word compare
module i2c_master_register_access_checker
  import i2cm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [DELAY_W-1:0] cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         func,
  input  logic [6:0]         dev_addr,
  input  logic [7:0]         reg_addr,
  input  logic [LEN_W-1:0]   length,
  input  logic [7:0]         wr_data,
  input  logic               sda_in,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               scl_low,
  input  logic               sda_low,
  input  logic [7:0]         rd_byte,
  input  logic               rd_valid,
  input  logic               rd_last,
  input  logic               need_byte,
  input  logic               busy_res,
  input  logic               done_res,
  input  logic               status,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic       rd_last;
    logic       need_byte;
    logic       busy;
    logic       done;
    logic       status;
  } pins_t;

  logic [DELAY_W-1:0] ticks_per_phase;
  phase_t             phase;
  stage_t             stage;
  logic [3:0]         bits_done;
  logic [7:0]         shifter;
  logic [LEN_W-1:0]   remaining;
  logic [DELAY_W-1:0] countdown;
  logic [6:0]         slave;
  logic [7:0]         regaddr;
  logic               rd_mode;
  logic               scl_drv;
  logic               sda_drv;
  logic               nacked;

  pins_t tick_outputs[$];
  int    fail_count = 0;
  int    queued_count = 0;

  assign errors  = fail_count;
  assign pending = queued_count;

  function automatic void reset_master();
    ticks_per_phase = DELAY_RESET;
    phase     = ST_IDLE;
    stage     = STG_ADDR_W;
    bits_done = '0;
    shifter   = '0;
    remaining = '0;
    countdown = '0;
    slave     = '0;
    regaddr   = '0;
    rd_mode   = 1'b0;
    scl_drv   = 1'b0;
    sda_drv   = 1'b0;
    nacked    = 1'b0;
  endfunction

  // zero delay counts as one tick
  function automatic void enter_phase(phase_t nxt);
    phase     = nxt;
    countdown = (ticks_per_phase == '0) ? 16'd1 : ticks_per_phase;
  endfunction

  function automatic void start_stop();
    sda_drv = 1'b1;
    enter_phase(ST_P1);
  endfunction

  function automatic void write_or_stop();
    if (remaining == '0) start_stop();
    else phase = ST_NEED;
  endfunction

  // first bit of a byte goes out msb first, sda pulled low for a zero
  function automatic void load_byte(logic [7:0] b);
    shifter   = b;
    bits_done = '0;
    sda_drv   = ~b[7];
    enter_phase(ST_WB_SET);
  endfunction

  function automatic void end_of_phase(input logic sda, inout pins_t p);
    case (phase)
      ST_S1: begin
        sda_drv = 1'b1;
        enter_phase(ST_S2);
      end
      ST_S2: begin
        scl_drv = 1'b1;
        enter_phase(ST_S3);
      end
      ST_S3: load_byte({slave, stage == STG_ADDR_R});
      ST_WB_SET: begin
        scl_drv = 1'b0;
        enter_phase(ST_WB_HI);
      end
      ST_WB_HI: begin
        scl_drv = 1'b1;
        enter_phase(ST_WB_LO);
      end
      ST_WB_LO: begin
        shifter   = {shifter[6:0], 1'b0};
        bits_done = bits_done + 4'd1;
        if (bits_done >= 4'd8) begin
          sda_drv = 1'b0;
          enter_phase(ST_WA_SET);
        end else begin
          sda_drv = ~shifter[7];
          enter_phase(ST_WB_SET);
        end
      end
      ST_WA_SET: begin
        scl_drv = 1'b0;
        enter_phase(ST_WA_HI);
      end
      ST_WA_HI: begin
        nacked  = sda;
        scl_drv = 1'b1;
        enter_phase(ST_WA_LO);
      end
      ST_WA_LO: begin
        if (nacked) begin
          start_stop();
        end else begin
          case (stage)
            STG_ADDR_W: begin
              stage = STG_REG;
              load_byte(regaddr);
            end
            STG_REG: begin
              if (rd_mode) begin
                stage   = STG_ADDR_R;
                scl_drv = 1'b0;
                sda_drv = 1'b0;
                enter_phase(ST_S1);
              end else begin
                stage = STG_DATA;
                write_or_stop();
              end
            end
            STG_DATA: write_or_stop();
            default: begin
              if (remaining == '0) begin
                start_stop();
              end else begin
                shifter   = '0;
                bits_done = '0;
                sda_drv   = 1'b0;
                enter_phase(ST_RB_SET);
              end
            end
          endcase
        end
      end
      ST_RB_SET: begin
        scl_drv = 1'b0;
        enter_phase(ST_RB_HI);
      end
      ST_RB_HI: begin
        shifter = {shifter[6:0], sda};
        scl_drv = 1'b1;
        enter_phase(ST_RB_LO);
      end
      ST_RB_LO: begin
        bits_done = bits_done + 4'd1;
        if (bits_done >= 4'd8) begin
          remaining  = remaining - 16'd1;
          p.rd_byte  = shifter;
          p.rd_valid = 1'b1;
          p.rd_last  = (remaining == '0);
          // ack all but the last byte
          sda_drv    = (remaining != '0);
          enter_phase(ST_RA_SET);
        end else begin
          sda_drv = 1'b0;
          enter_phase(ST_RB_SET);
        end
      end
      ST_RA_SET: begin
        scl_drv = 1'b0;
        enter_phase(ST_RA_HI);
      end
      ST_RA_HI: begin
        scl_drv = 1'b1;
        enter_phase(ST_RA_LO);
      end
      ST_RA_LO: begin
        if (remaining == '0) begin
          start_stop();
        end else begin
          sda_drv   = 1'b0;
          bits_done = '0;
          shifter   = '0;
          enter_phase(ST_RB_SET);
        end
      end
      ST_P1: begin
        scl_drv = 1'b0;
        enter_phase(ST_P2);
      end
      ST_P2: begin
        sda_drv = 1'b0;
        enter_phase(ST_P3);
      end
      ST_P3: begin
        phase     = ST_IDLE;
        countdown = '0;
        p.done    = 1'b1;
      end
      default: begin
        phase     = ST_IDLE;
        countdown = '0;
        scl_drv   = 1'b0;
        sda_drv   = 1'b0;
      end
    endcase
  endfunction

  function automatic void master_tick(input cmd_t cmd, input logic [6:0] da,
                                      input logic [7:0] ra, input logic [LEN_W-1:0] len,
                                      input logic [7:0] wd, input logic sda,
                                      output pins_t p);
    p = '0;
    if (phase == ST_IDLE) begin
      if (cmd == CMD_BEGIN_WR || cmd == CMD_BEGIN_RD) begin
        slave     = da;
        regaddr   = ra;
        remaining = len;
        rd_mode   = (cmd == CMD_BEGIN_RD);
        stage     = STG_ADDR_W;
        nacked    = 1'b0;
        bits_done = '0;
        shifter   = '0;
        scl_drv   = 1'b0;
        sda_drv   = 1'b0;
        enter_phase(ST_S1);
      end
    end else if (phase == ST_NEED) begin
      if (cmd == CMD_DATA) begin
        remaining = remaining - 16'd1;
        load_byte(wd);
      end
    end else if (countdown > 16'd1) begin
      countdown = countdown - 16'd1;
    end else begin
      end_of_phase(sda, p);
    end
    p.scl_low   = scl_drv;
    p.sda_low   = sda_drv;
    p.need_byte = (phase == ST_NEED);
    p.busy      = (phase != ST_IDLE);
    p.status    = nacked;
  endfunction

  always @(posedge clk) begin
    pins_t want;
    pins_t seen;
    if (rst) begin
      reset_master();
      tick_outputs.delete();
    end else begin
      if (cfg_we) ticks_per_phase = cfg_wdata;
      // results first, so a word never pairs with an item taken at the same edge
      if (out_valid && !out_stall) begin
        seen = {scl_low, sda_low, rd_byte, rd_valid, rd_last, need_byte, busy_res,
                done_res, status};
        if (tick_outputs.size() == 0) begin
          $display("%0t: result word with nothing outstanding, actual %h", $time, seen);
          fail_count = fail_count + 1;
        end else begin
          want = tick_outputs.pop_front();
          if (seen !== want) begin
            $display({"%0t: mismatch scl sda rd_byte rd_valid rd_last need busy done status",
                      " expected %b %b %h %b %b %b %b %b %b actual %b %b %h %b %b %b %b %b %b"},
                     $time, want.scl_low, want.sda_low, want.rd_byte, want.rd_valid,
                     want.rd_last, want.need_byte, want.busy, want.done, want.status,
                     seen.scl_low, seen.sda_low, seen.rd_byte, seen.rd_valid,
                     seen.rd_last, seen.need_byte, seen.busy, seen.done, seen.status);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        master_tick(cmd_t'(func), dev_addr, reg_addr, length, wr_data, sda_in, want);
        tick_outputs.push_back(want);
      end
    end
    queued_count <= tick_outputs.size();
  end

endmodule

/* bench/i2c_master_register_access_core_test.sv */
// testbench top of the i2c master register access core: stimulus and verdict
module i2c_master_register_access_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cm_pkg::*;

  // slowest run is well under this: ~2.5k words, with the receiver stalling at its worst rate
  localparam int CYCLE_LIMIT = 1_000_000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [DELAY_W-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         func = CMD_TICK;
  logic [6:0]         dev_addr = '0;
  logic [7:0]         reg_addr = '0;
  logic [LEN_W-1:0]   length = '0;
  logic [7:0]         wr_data = '0;
  logic               sda_in = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               scl_low;
  logic               sda_low;
  logic [7:0]         rd_byte;
  logic               rd_valid;
  logic               rd_last;
  logic               need_byte;
  logic               busy_res;
  logic               done_res;
  logic               status;

  int errors;
  int pending;

  // idle rates in percent per cycle, and the chance that the slave leaves sda high
  int send_idle_pct = 0;
  int stall_pct = 0;
  int ones_pct = 5;

  // word counts on both sides, and the bus flags of the latest result word
  int   words_sent = 0;
  int   words_seen = 0;
  logic last_need = 1'b0;
  logic last_busy = 1'b0;
  int   cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  i2c_master_register_access_core i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .dev_addr(dev_addr), .reg_addr(reg_addr), .length(length),
    .wr_data(wr_data), .sda_in(sda_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .scl_low(scl_low), .sda_low(sda_low), .rd_byte(rd_byte), .rd_valid(rd_valid),
    .rd_last(rd_last), .need_byte(need_byte), .busy_res(busy_res),
    .done_res(done_res), .status(status)
  );

  i2c_master_register_access_checker i_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .dev_addr(dev_addr), .reg_addr(reg_addr), .length(length),
    .wr_data(wr_data), .sda_in(sda_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .scl_low(scl_low), .sda_low(sda_low), .rd_byte(rd_byte), .rd_valid(rd_valid),
    .rd_last(rd_last), .need_byte(need_byte), .busy_res(busy_res),
    .done_res(done_res), .status(status),
    .errors(errors), .pending(pending)
  );

  // receiver stalls at random, rate set per phase of the run
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // bus flags seen on the result side steer the stimulus
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      words_seen <= words_seen + 1;
      last_need  <= need_byte;
      last_busy  <= busy_res;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // one word, after a random idle gap; returns at the edge that takes it
  task automatic send_word(input logic [1:0] f, input logic [6:0] da, input logic [7:0] ra,
                           input logic [LEN_W-1:0] len, input logic [7:0] wd,
                           input logic sd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    dev_addr <= da;
    reg_addr <= ra;
    length   <= len;
    wr_data  <= wd;
    sda_in   <= sd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // ticks with junk in the unused fields until a later result word shows
  // the engine waiting for a byte or back in idle
  task automatic settle(input int pct);
    int mark;
    mark = words_sent;
    do begin
      send_word(CMD_TICK, 7'($urandom), 8'($urandom), LEN_W'($urandom), 8'($urandom),
                $urandom_range(99) < pct);
    end while (!(words_seen > mark && (last_need || !last_busy)));
  endtask

  // sender pauses until every result word has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0 || words_seen != words_sent) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_delay(input logic [DELAY_W-1:0] ticks);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // close whatever a random stretch left open: the slave nacks so writes stop fast
  task automatic close_transfer();
    settle(100);
    while (last_need) begin
      send_word(CMD_DATA, 7'($urandom), 8'($urandom), LEN_W'($urandom), 8'($urandom), 1'b1);
      settle(100);
    end
  endtask

  // mostly ticks and data words, with a begin now and then; lengths stay short
  // so transfers finish, a few writes take a full 16 bit length
  task automatic random_words(input int n);
    int               k;
    int               r;
    logic [1:0]       f;
    logic [LEN_W-1:0] len;
    for (k = 0; k < n; k++) begin
      r   = $urandom_range(99);
      len = LEN_W'($urandom);
      if (r < 4) begin
        f = $urandom_range(1) ? CMD_BEGIN_RD : CMD_BEGIN_WR;
        if (f == CMD_BEGIN_RD) begin
          len = ($urandom_range(99) < 85) ? LEN_W'($urandom_range(3))
                                          : LEN_W'($urandom_range(8, 4));
        end else begin
          r   = $urandom_range(99);
          len = (r < 80) ? LEN_W'($urandom_range(3)) :
                (r < 97) ? LEN_W'($urandom_range(12, 4)) : LEN_W'($urandom);
        end
        // mostly a well-behaved slave, sometimes one that nacks a lot
        r = $urandom_range(9);
        ones_pct = (r < 6) ? 3 : (r < 8) ? 25 : 60;
      end else if (r < 30) begin
        f = CMD_DATA;
      end else begin
        f = CMD_TICK;
      end
      send_word(f, 7'($urandom), 8'($urandom), len, 8'($urandom),
                $urandom_range(99) < ones_pct);
    end
  endtask

  task automatic directed_words();
    // stray byte while idle, then ticks with every field at its extremes
    send_word(CMD_DATA, 7'h00, 8'h00, 16'h0000, 8'hA5, 1'b0);
    send_word(CMD_TICK, 7'h7F, 8'hFF, 16'hFFFF, 8'hFF, 1'b1);
    send_word(CMD_TICK, 7'h00, 8'h00, 16'h0000, 8'h00, 1'b0);
    // one byte write; a begin while busy and an early byte are both ignored
    send_word(CMD_BEGIN_WR, 7'h7F, 8'hFF, 16'd1, 8'h00, 1'b0);
    send_word(CMD_BEGIN_RD, 7'h00, 8'h00, 16'd5, 8'h00, 1'b0);
    send_word(CMD_DATA, 7'h00, 8'h00, 16'h0000, 8'h5A, 1'b0);
    settle(0);
    send_word(CMD_DATA, 7'h00, 8'h00, 16'h0000, 8'hFF, 1'b0);
    settle(0);
    // zero length write and zero length read
    send_word(CMD_BEGIN_WR, 7'h00, 8'h00, 16'd0, 8'h00, 1'b0);
    settle(0);
    send_word(CMD_BEGIN_RD, 7'h55, 8'hAA, 16'd0, 8'h00, 1'b0);
    settle(0);
    // three byte read with a repeated start, then one whose address is nacked
    send_word(CMD_BEGIN_RD, 7'h2A, 8'h81, 16'd3, 8'h00, 1'b0);
    settle(0);
    send_word(CMD_BEGIN_RD, 7'h33, 8'h0F, 16'd2, 8'h00, 1'b0);
    settle(100);
    // longest write, ended by a nack on the second data byte
    send_word(CMD_BEGIN_WR, 7'h7F, 8'h00, 16'hFFFF, 8'h00, 1'b0);
    settle(0);
    send_word(CMD_DATA, 7'h00, 8'h00, 16'h0000, 8'h00, 1'b0);
    settle(0);
    send_word(CMD_DATA, 7'h00, 8'h00, 16'h0000, 8'h80, 1'b0);
    settle(100);
    // a new begin clears the error status
    send_word(CMD_BEGIN_WR, 7'h01, 8'h80, 16'd0, 8'h00, 1'b0);
    settle(0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender idles a little, receiver a lot
    send_idle_pct = 29;
    stall_pct    <= 82;
    // zero delay behaves as one tick per phase
    set_delay(16'd0);
    directed_words();
    set_delay(16'd1);
    random_words(350);
    set_delay(16'd2);
    random_words(250);

    // the other way round
    send_idle_pct = 82;
    stall_pct    <= 29;
    set_delay(16'd3);
    random_words(300);
    set_delay(16'd1);
    random_words(250);

    // no idling; one start phase at a long delay, then back to short phases
    send_idle_pct = 0;
    stall_pct    <= 0;
    close_transfer();
    set_delay(16'd100);
    send_word(CMD_BEGIN_WR, 7'h15, 8'h3C, 16'd0, 8'h00, 1'b0);
    set_delay(16'd1);
    settle(0);
    random_words(300);

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
